// ===== sv/vrs_pkg.sv =====
`timescale 1ns / 1ps

package vrs_pkg;

    // Default build parameters.
    localparam int DEF_MAX_LEN     = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 8;

    localparam int VALUE_W  = 64;
    localparam int STAT_W   = 2;
    localparam int STATUS_W = 2;

    // Statistic selection codes.
    localparam logic [STAT_W-1:0] STAT_MEAN  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SUM   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SUMSQ = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SD    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_SD_ONE   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_TOO_LONG = 2'd2;

endpackage

// ===== sv/vector_running_statistics_core.sv =====
`timescale 1ns / 1ps
// Input side takes one sample per cycle while the job queue has room.
// Sum, sum of squares and error results pass from the closing sample through the
// job queue, the back-end state machine and the output register. Mean adds a
// restoring division over every dividend bit; standard deviation adds shift-and-add
// multiplies over the bits of n and |sum|, the division and a square root.
// Active-low synchronous reset clears accumulators, queue, statistic and output valid.

module vector_running_statistics_core import vrs_pkg::*; #(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [STAT_W-1:0]             i_cfg_statistic,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last_in_vector,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_W-1:0]     o_value,
    output logic [STATUS_W-1:0]           o_status
);

    // Width of one queued job: selection, status, count, sum and sum of squares.
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int SW    = SAMPLE_BITS + CW;
    localparam int QW    = 2 * SAMPLE_BITS - 2 + CW;
    localparam int JOB_W = STAT_W + STATUS_W + CW + SW + QW;

    logic [STAT_W-1:0] r_statistic;
    logic              take;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [JOB_W-1:0]  q_in;
    logic [JOB_W-1:0]  q_out;

    // Always ready; the user must write the statistic only while idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_statistic <= STAT_MEAN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_statistic <= i_cfg_statistic;
        end
    end

    // Samples are held off only when the job queue cannot take a closing request.
    assign o_in_stall = q_full;
    assign take       = i_in_valid && !q_full;

    // Front end: accumulates each vector and turns its closing sample into a job.
    vrs_front #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_sample (i_sample),
        .i_last   (i_last_in_vector),
        .i_stat   (r_statistic),
        .o_push   (q_push),
        .o_job    (q_in)
    );

    // Two-entry queue lets the next vector accumulate while the back end divides.
    vrs_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end: sequential multiply, divide and square root, then the output register.
    vrs_back #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (q_out),
        .o_job_pop   (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_status    (o_status)
    );

    // A job is never pushed into a full queue, since the input is stalled then.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    // A too-long vector always reports a zero value.
    a_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STS_TOO_LONG) |-> (o_value == '0))
        else $error("too-long result carries a nonzero value");

    // A one-element deviation request always reports a zero value.
    a_one_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STS_SD_ONE) |-> (o_value == '0))
        else $error("one-element deviation result carries a nonzero value");

    // No result is presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

// ===== sv/vrs_queue.sv =====
`timescale 1ns / 1ps

module vrs_queue import vrs_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_data [DEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_data  = r_data[r_rp];
    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

endmodule

// ===== sv/vrs_front.sv =====
`timescale 1ns / 1ps

module vrs_front import vrs_pkg::*; #(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int CW    = $clog2(MAX_LEN + 1),
    localparam int SW    = SAMPLE_BITS + CW,
    localparam int QW    = 2 * SAMPLE_BITS - 2 + CW,
    localparam int JOB_W = STAT_W + STATUS_W + CW + SW + QW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    input  logic [STAT_W-1:0]             i_stat,
    output logic                          o_push,
    output logic [JOB_W-1:0]              o_job
);

    typedef struct packed {
        logic [STAT_W-1:0]   stat;
        logic [STATUS_W-1:0] status;
        logic [CW-1:0]       n;
        logic signed [SW-1:0] sum;
        logic [QW-1:0]       sumsq;
    } t_job;

    logic [CW-1:0]                  r_count, n_count;
    logic signed [SW-1:0]           r_sum, n_sum;
    logic [QW-1:0]                  r_sumsq, n_sumsq;
    logic                           r_over, n_over;
    logic signed [2*SAMPLE_BITS-1:0] sq;
    t_job                           job;

    assign sq = i_sample * i_sample;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_over  = r_over;
        if (r_count >= CW'(MAX_LEN)) begin
            n_over = 1'b1;
        end else begin
            n_count = r_count + CW'(1);
            n_sum   = r_sum + SW'(i_sample);
            n_sumsq = r_sumsq + QW'($unsigned(sq));
        end

        job.stat  = i_stat;
        job.n     = n_count;
        job.sum   = n_sum;
        job.sumsq = n_sumsq;
        if (n_over) begin
            job.status = STS_TOO_LONG;
        end else if (i_stat == STAT_SD && n_count < CW'(2)) begin
            job.status = STS_SD_ONE;
        end else begin
            job.status = STS_OK;
        end
    end

    assign o_push = i_take && i_last;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_over  <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
                r_over  <= 1'b0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_sumsq <= n_sumsq;
                r_over  <= n_over;
            end
        end
    end

endmodule

// ===== sv/vrs_back.sv =====
`timescale 1ns / 1ps

module vrs_back import vrs_pkg::*; #(
    parameter int MAX_LEN     = DEF_MAX_LEN,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    localparam int CW    = $clog2(MAX_LEN + 1),
    localparam int SW    = SAMPLE_BITS + CW,
    localparam int QW    = 2 * SAMPLE_BITS - 2 + CW,
    localparam int JOB_W = STAT_W + STATUS_W + CW + SW + QW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_empty,
    input  logic [JOB_W-1:0]           i_job,
    output logic                       o_job_pop,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int MW   = SW - 1;
    localparam int NW   = CW + QW;
    localparam int DW   = NW + 2 * FRAC_BITS;
    localparam int DVW  = 2 * CW;
    localparam int RW   = 2 * ((DW + 1) / 2);
    localparam int RTW  = RW / 2;
    localparam int CNTW = $clog2(DW + 1);

    typedef struct packed {
        logic [STAT_W-1:0]   stat;
        logic [STATUS_W-1:0] status;
        logic [CW-1:0]       n;
        logic signed [SW-1:0] sum;
        logic [QW-1:0]       sumsq;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_N,
        S_MUL_SQ,
        S_DIV,
        S_SQRT,
        S_PUT
    } t_state;

    t_state               r_state;
    logic [STAT_W-1:0]    r_sel;
    logic [STATUS_W-1:0]  r_sts;
    logic                 r_neg;
    logic [MW-1:0]        r_mag;
    logic [NW-1:0]        r_acc;
    logic [NW-1:0]        r_mcand;
    logic [MW-1:0]        r_mplier;
    logic [DVW-1:0]       r_dacc;
    logic [DVW-1:0]       r_dcand;
    logic [DW-1:0]        r_dvd;
    logic [DVW-1:0]       r_rem;
    logic [RW-1:0]        r_rad;
    logic [RTW-1:0]       r_root;
    logic [RTW+1:0]       r_srem;
    logic [CNTW-1:0]      r_cnt;
    logic [VALUE_W-1:0]   r_res;
    logic                 r_ovalid;
    logic [VALUE_W-1:0]   r_oval;
    logic [STATUS_W-1:0]  r_osts;

    t_job                 job;
    logic signed [SW-1:0] sum_abs;
    logic [MW-1:0]        job_mag;
    logic [DVW:0]         rem_sh;
    logic                 div_ok;
    logic [DVW-1:0]       rem_nx;
    logic [DW-1:0]        dvd_nx;
    logic [RTW+1:0]       srem_sh;
    logic [RTW+1:0]       trial;
    logic                 sq_ok;
    logic [RTW+1:0]       srem_nx;
    logic [RTW-1:0]       root_nx;
    logic                 out_free;

    always_comb begin
        job     = t_job'(i_job);
        sum_abs = job.sum[SW-1] ? -job.sum : job.sum;
        job_mag = sum_abs[MW-1:0];

        // One restoring division step.
        rem_sh = {r_rem, r_dvd[DW-1]};
        div_ok = (rem_sh >= {1'b0, r_dacc});
        rem_nx = div_ok ? DVW'(rem_sh - {1'b0, r_dacc}) : rem_sh[DVW-1:0];
        dvd_nx = {r_dvd[DW-2:0], div_ok};

        // One digit of the square root.
        srem_sh = {r_srem[RTW-1:0], r_rad[RW-1 -: 2]};
        trial   = {r_root, 2'b01};
        sq_ok   = (srem_sh >= trial);
        srem_nx = sq_ok ? (srem_sh - trial) : srem_sh;
        root_nx = {r_root[RTW-2:0], sq_ok};
    end

    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_job_pop   = (r_state == S_IDLE) && !i_job_empty;
    assign o_out_valid = r_ovalid;
    assign o_value     = r_oval;
    assign o_status    = r_osts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && r_state != S_PUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_sel <= job.stat;
                        r_sts <= job.status;
                        r_neg <= job.sum[SW-1];
                        r_mag <= job_mag;
                        r_cnt <= '0;
                        r_rem <= '0;
                        if (job.status != STS_OK) begin
                            r_res   <= '0;
                            r_state <= S_PUT;
                        end else begin
                            case (job.stat)
                                STAT_SUM: begin
                                    r_res   <= VALUE_W'(job.sum);
                                    r_state <= S_PUT;
                                end
                                STAT_SUMSQ: begin
                                    r_res   <= VALUE_W'(job.sumsq);
                                    r_state <= S_PUT;
                                end
                                STAT_MEAN: begin
                                    r_dvd   <= DW'(job_mag) << FRAC_BITS;
                                    r_dacc  <= DVW'(job.n);
                                    r_state <= S_DIV;
                                end
                                default: begin
                                    r_acc    <= '0;
                                    r_mcand  <= NW'(job.sumsq);
                                    r_mplier <= MW'(job.n);
                                    r_dacc   <= '0;
                                    r_dcand  <= DVW'(job.n) - DVW'(1);
                                    r_state  <= S_MUL_N;
                                end
                            endcase
                        end
                    end
                end
                S_MUL_N: begin
                    // n * sumsq and n * (n - 1) share the bits of n.
                    if (r_mplier == '0) begin
                        r_mcand  <= NW'(r_mag);
                        r_mplier <= r_mag;
                        r_state  <= S_MUL_SQ;
                    end else begin
                        if (r_mplier[0]) begin
                            r_acc  <= r_acc + r_mcand;
                            r_dacc <= r_dacc + r_dcand;
                        end
                        r_mcand  <= r_mcand << 1;
                        r_dcand  <= r_dcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_MUL_SQ: begin
                    // Subtract sum squared; the total never goes below zero.
                    if (r_mplier == '0) begin
                        r_dvd   <= DW'(r_acc) << (2 * FRAC_BITS);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc - r_mcand;
                        end
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_DIV: begin
                    r_rem <= rem_nx;
                    r_dvd <= dvd_nx;
                    if (r_cnt == CNTW'(DW - 1)) begin
                        r_cnt <= '0;
                        if (r_sel == STAT_SD) begin
                            r_rad   <= RW'(dvd_nx);
                            r_root  <= '0;
                            r_srem  <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_res   <= r_neg ? -VALUE_W'(dvd_nx) : VALUE_W'(dvd_nx);
                            r_state <= S_PUT;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNTW'(1);
                    end
                end
                S_SQRT: begin
                    r_srem <= srem_nx;
                    r_root <= root_nx;
                    r_rad  <= r_rad << 2;
                    r_cnt  <= r_cnt + CNTW'(1);
                    if (r_cnt == CNTW'(RTW - 1)) begin
                        r_res   <= VALUE_W'(root_nx);
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_res;
                        r_osts   <= r_sts;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import vrs_pkg::*;

    // Sample requests come from a queue that the sequencing block fills phase
    // by phase; a clocked driver offers them to the core, and every accepted
    // request is folded into a local copy of the accumulators. A closing sample
    // turns that copy into the expected result. A clocked monitor takes results
    // from the core and compares each one with the oldest expected result.

    localparam int MAX_LEN     = DEF_MAX_LEN;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int FRAC_BITS   = DEF_FRAC_BITS;

    // The settle time allows for the slowest result, the standard deviation.
    localparam int SETTLE_CYCLES = 600;
    localparam int DRAIN_LIMIT   = 400000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 30;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } sample_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } stat_result_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [STAT_W-1:0]             i_cfg_statistic = STAT_MEAN;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                          i_last_in_vector = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [VALUE_W-1:0]     o_value;
    logic [STATUS_W-1:0]           o_status;

    vector_running_statistics_core #(
        .MAX_LEN    (MAX_LEN),
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_statistic (i_cfg_statistic),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sample        (i_sample),
        .i_last_in_vector(i_last_in_vector),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value         (o_value),
        .o_status        (o_status)
    );

    always #1 i_clk = ~i_clk;

    sample_req_t  pending_reqs[$];
    stat_result_t expected_stats[$];
    int           mismatches = 0;

    // Local copy of the accumulators and of the statistic register.
    int unsigned       acc_count = 0;
    logic signed [63:0] acc_sum = '0;
    logic [63:0]       acc_sumsq = '0;
    logic              acc_too_long = 1'b0;
    logic [STAT_W-1:0] active_statistic = STAT_MEAN;

    // Idling controls; the sequencing block sets the percentages and long hold per phase.
    int   in_idle_pct = 0;
    int   out_idle_pct = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   long_hold_left = 0;
    logic long_hold_req = 1'b0;

    // Folds one accepted sample into the accumulators. A closing sample
    // computes the chosen statistic and clears the accumulators.
    task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
        logic signed [63:0] s64;
        logic [63:0]        n;
        logic [63:0]        mag;
        logic [63:0]        quot;
        logic [63:0]        root;
        logic [63:0]        cand;
        logic [127:0]       num;
        logic [127:0]       radicand;
        logic               neg;
        stat_result_t       res;
        s64 = s;
        if (acc_count >= MAX_LEN) begin
            acc_too_long = 1'b1;
        end else begin
            acc_count++;
            acc_sum = acc_sum + s64;
            acc_sumsq = acc_sumsq + 64'(s64 * s64);
        end
        if (!last) return;

        n = 64'(acc_count);
        neg = acc_sum < 0;
        mag = neg ? 64'(-acc_sum) : 64'(acc_sum);
        res.value = '0;
        res.status = STS_OK;
        if (acc_too_long) begin
            // Overlong vectors report an error whatever the statistic.
            res.status = STS_TOO_LONG;
        end else begin
            case (active_statistic)
                STAT_MEAN: begin
                    // Truncation toward zero: divide the magnitude, then restore the sign.
                    quot = (mag << FRAC_BITS) / n;
                    res.value = neg ? -quot : quot;
                end
                STAT_SUM:   res.value = acc_sum;
                STAT_SUMSQ: res.value = acc_sumsq;
                default: begin
                    if (n < 2) begin
                        res.status = STS_SD_ONE;
                    end else begin
                        num = 128'(n) * 128'(acc_sumsq) - 128'(mag) * 128'(mag);
                        num = num << (2 * FRAC_BITS);
                        radicand = num / (128'(n) * 128'(n - 1));
                        root = '0;
                        for (int b = 62; b >= 0; b--) begin
                            cand = root | (64'd1 << b);
                            if (128'(cand) * 128'(cand) <= radicand) root = cand;
                        end
                        res.value = root;
                    end
                end
            endcase
        end
        expected_stats.push_back(res);
        acc_count = 0;
        acc_sum = '0;
        acc_sumsq = '0;
        acc_too_long = 1'b0;
    endtask

    // Driver: a request stays on the port until the core takes it.
    always @(posedge i_clk) begin : drive_samples
        logic taken;
        taken = i_rst_n && i_in_valid && !o_in_stall;
        if (taken) begin
            absorb_sample(i_sample, i_last_in_vector);
            void'(pending_reqs.pop_front());
        end
        if (!(i_in_valid && !taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (i_rst_n && pending_reqs.size() != 0
                         && $urandom_range(0, 99) < in_idle_pct) begin
                gap_left = $urandom_range(0, 15);
                i_in_valid <= 1'b0;
            end else if (i_rst_n && pending_reqs.size() != 0) begin
                i_in_valid <= 1'b1;
                i_sample <= pending_reqs[0].sample;
                i_last_in_vector <= pending_reqs[0].last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each taken result and decides the next stall.
    always @(posedge i_clk) begin : check_results
        stat_result_t want;
        logic         stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_stats.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                         $time, o_value, o_status);
                mismatches++;
            end else begin
                want = expected_stats.pop_front();
                if (o_value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, $signed(want.value), o_value);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                    mismatches++;
                end
            end
        end
        if (long_hold_req) begin
            long_hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (long_hold_left > 0) begin
            long_hold_left--;
            stall_next = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
        end else if ($urandom_range(0, 99) < out_idle_pct) begin
            stall_left = $urandom_range(0, 15);
            stall_next = 1'b1;
        end else begin
            stall_next = 1'b0;
        end
        i_out_stall <= stall_next;
    end

    task automatic wait_for_idle();
        int spent;
        spent = 0;
        while ((pending_reqs.size() != 0 || i_in_valid || expected_stats.size() != 0)
               && spent < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spent++;
        end
    endtask

    // Register writes only happen with the core drained and settled.
    task automatic write_statistic(input logic [STAT_W-1:0] v);
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_statistic <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_statistic = v;
        @(negedge i_clk);
    endtask

    function automatic void push_req(input logic signed [SAMPLE_BITS-1:0] s, input logic last);
        sample_req_t r;
        r.sample = s;
        r.last = last;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(input int style);
        int v;
        case (style)
            0: return SAMPLE_BITS'($urandom());
            1: begin
                case ($urandom_range(0, 4))
                    0: return SMP_MIN;
                    1: return SMP_MAX;
                    2: return SAMPLE_BITS'(-1);
                    3: return SAMPLE_BITS'(0);
                    default: return SAMPLE_BITS'(1);
                endcase
            end
            default: begin
                v = $urandom_range(0, 15);
                return SAMPLE_BITS'(v - 8);
            end
        endcase
    endfunction

    // Pushes one closed vector of random length and content; returns its length.
    function automatic int push_vector();
        int len;
        int style;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) len = $urandom_range(1, 4);
        else if (pick < 18) len = $urandom_range(5, 16);
        else len = $urandom_range(17, 64);
        pick = $urandom_range(0, 9);
        style = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
        for (int i = 0; i < len; i++) push_req(rand_sample(style), i == len - 1);
        return len;
    endfunction

    initial begin : sequencer
        int               phase_items;
        logic [STAT_W-1:0] stat;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, mean from the reset value of the register:
        // extremes, zero and a negative mean that truncates toward zero.
        push_req(SMP_MAX, 1'b1);
        push_req(SMP_MIN, 1'b1);
        push_req(SAMPLE_BITS'(0), 1'b1);
        push_req(SAMPLE_BITS'(-1), 1'b0);
        push_req(SAMPLE_BITS'(-1), 1'b0);
        push_req(SAMPLE_BITS'(1), 1'b1);

        write_statistic(STAT_SUM);
        push_req(SMP_MAX, 1'b0);
        push_req(SMP_MAX, 1'b1);
        push_req(SMP_MIN, 1'b0);
        push_req(SMP_MIN, 1'b0);
        push_req(SMP_MIN, 1'b1);

        write_statistic(STAT_SUMSQ);
        push_req(SMP_MIN, 1'b0);
        push_req(SMP_MIN, 1'b1);
        push_req(SAMPLE_BITS'(5), 1'b1);

        // Standard deviation: a one-element vector, extremes, and zero spread.
        write_statistic(STAT_SD);
        push_req(SAMPLE_BITS'(7), 1'b1);
        push_req(SMP_MIN, 1'b0);
        push_req(SMP_MAX, 1'b1);
        push_req(SAMPLE_BITS'(3), 1'b0);
        push_req(SAMPLE_BITS'(3), 1'b0);
        push_req(SAMPLE_BITS'(3), 1'b1);

        // Random phases. The last few run without idling on either side.
        for (int phase = 0; phase < 14; phase++) begin
            if (phase < 4) stat = STAT_W'(3 - phase);
            else if (phase == 5) stat = STAT_SUM;
            else if (phase == 7) stat = STAT_SUMSQ;
            else if (phase == 9) stat = STAT_SD;
            else stat = STAT_W'($urandom_range(0, 3));
            write_statistic(stat);
            in_idle_pct = (phase >= 11 || phase % 3 == 2 || phase == 5) ? 0 : 20;
            out_idle_pct = (phase >= 11 || phase % 4 == 3) ? 0 : 20;
            phase_items = 0;
            if (phase == 5) begin
                // Back-pressure: the receiver holds off while single-sample
                // vectors keep coming, so the core has to stall its input.
                long_hold_req = 1'b1;
                for (int i = 0; i < 80; i++) push_req(rand_sample(0), 1'b1);
                phase_items = 80;
            end else if (phase == 9) begin
                // One element past the limit; the error wins over the statistic.
                for (int i = 0; i <= MAX_LEN; i++) push_req(rand_sample(0), i == MAX_LEN);
            end
            while (phase_items < PHASE_ITEMS) phase_items += push_vector();
        end

        wait_for_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_stats.size() != 0 || pending_reqs.size() != 0) begin
            $display("%0t: %0d results still expected, %0d requests not taken",
                     $time, expected_stats.size(), pending_reqs.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
